// File: rtl/opta_pkg.sv
// Shared types, constants and helper functions for the outer product tile accumulator.
package opta_pkg;

  localparam int unsigned TileRowsDef = 16;
  localparam int unsigned TileColsDef = 6;
  localparam int unsigned AccBitsDef  = 48;
  localparam int unsigned LaneRows    = 16;
  localparam int unsigned LaneCols    = 6;
  localparam int unsigned OutPairs    = 8;
  localparam int unsigned PayWords    = 8;
  localparam int unsigned QBits       = 16;
  localparam int unsigned CBits       = 32;
  localparam int unsigned CmdBits     = 2;
  localparam int unsigned SelBits     = 3;
  localparam int unsigned CfgIdxBits  = 1;
  localparam int unsigned CfgDatBits  = 5;

  typedef enum logic [CmdBits-1:0] {
    CmdStep    = 2'd0,
    CmdEmit    = 2'd1,
    CmdPreload = 2'd2,
    CmdNone    = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxBits-1:0] {
    RegRowsUsed = 1'd0,
    RegColsUsed = 1'd1
  } reg_e;

  typedef logic [63:0] word_t;

  typedef struct packed {
    logic [CmdBits-1:0] cmd;
    logic [SelBits-1:0] col_select;
    word_t              payload0;
    word_t              payload1;
    word_t              payload2;
    word_t              payload3;
    word_t              payload4;
    word_t              payload5;
    word_t              payload6;
    word_t              payload7;
  } in_item_t;

  typedef struct packed {
    logic [CfgIdxBits-1:0] index;
    logic [CfgDatBits-1:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic [SelBits-1:0] col_index;
    logic               last;
    word_t              out_pair0;
    word_t              out_pair1;
    word_t              out_pair2;
    word_t              out_pair3;
    word_t              out_pair4;
    word_t              out_pair5;
    word_t              out_pair6;
    word_t              out_pair7;
  } out_item_t;

  typedef struct packed {
    logic                  do_step;
    logic                  do_emit;
    logic                  do_load;
    logic [SelBits-1:0]    sel;
    logic [LaneRows-1:0]   row_en;
    logic [LaneCols-1:0]   col_en;
    logic [SelBits-1:0]    ncols;
    word_t [PayWords-1:0]  pay;
  } op_t;

endpackage

// File: rtl/opta_if.sv
// Valid and ready channel interface carrying a generic payload.
interface opta_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/opta_front.sv
// Front end: accepts items, decodes the command and applies the row and column masks.
module opta_front
  import opta_pkg::*;
#(
  parameter int unsigned TileRows = TileRowsDef,
  parameter int unsigned TileCols = TileColsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [CmdBits-1:0]         cmd_i,
  input  logic [SelBits-1:0]         col_select_i,
  input  word_t [PayWords-1:0]       pay_i,
  input  logic                       cfg_valid_i,
  input  logic [CfgIdxBits-1:0]      cfg_index_i,
  input  logic [CfgDatBits-1:0]      cfg_data_i,
  output logic                       op_valid_o,
  input  logic                       op_ready_i,
  output op_t                        op_o
);

  logic [4:0] rows_used_q;
  logic [2:0] cols_used_q;
  logic       full_q;
  op_t        op_q, op_d;
  logic       take;

  assign in_ready_o = !full_q || op_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_used_q <= 5'd16;
      cols_used_q <= 3'd6;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        RegRowsUsed: rows_used_q <= cfg_data_i;
        RegColsUsed: cols_used_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [2:0] nc;
    nc = (32'(cols_used_q) > TileCols) ? 3'(TileCols) : cols_used_q;
    op_d          = '0;
    op_d.pay      = pay_i;
    op_d.sel      = col_select_i;
    op_d.ncols    = (nc > 3'(LaneCols)) ? 3'(LaneCols) : nc;
    for (int r = 0; r < LaneRows; r++) begin
      op_d.row_en[r] = (r < TileRows) && (r < 32'(rows_used_q));
    end
    for (int c = 0; c < LaneCols; c++) begin
      op_d.col_en[c] = (c < TileCols) && (c < 32'(nc));
    end
    unique case (cmd_e'(cmd_i))
      CmdStep: op_d.do_step = 1'b1;
      CmdEmit: begin
        op_d.do_step = 1'b1;
        op_d.do_emit = 1'b1;
      end
      CmdPreload: op_d.do_load = 32'(col_select_i) < TileCols;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (in_ready_o) begin
      full_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q <= op_d;
    end
  end

  assign op_valid_o = full_q;
  assign op_o       = op_q;

endmodule

// File: rtl/opta_back.sv
// Back end: multiply stage, saturating accumulator tile and column emit sequencer.
module opta_back
  import opta_pkg::*;
#(
  parameter int unsigned TileRows = TileRowsDef,
  parameter int unsigned TileCols = TileColsDef,
  parameter int unsigned AccBits  = AccBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 op_valid_i,
  output logic                 op_ready_o,
  input  op_t                  op_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SelBits-1:0]   col_index_o,
  output logic                 last_o,
  output word_t [OutPairs-1:0] pair_o
);

  localparam int unsigned PBits = 2 * QBits;

  typedef logic signed [AccBits-1:0] acc_t;

  // Stage 1 registers: products or preload values.
  logic                              s1_q;
  logic                              s1_step_q, s1_emit_q, s1_load_q;
  logic [SelBits-1:0]                s1_sel_q, s1_ncols_q;
  logic [LaneRows-1:0]               s1_row_q;
  logic [LaneCols-1:0]               s1_col_q;
  logic signed [PBits-1:0]           prod_q [LaneRows][LaneCols];
  logic signed [CBits-1:0]           cval_q [LaneRows];

  acc_t                              acc_q [TileRows][TileCols];

  // Emit snapshot and sequencer.
  logic                              busy_q;
  logic [SelBits-1:0]                k_q, n_q;
  logic [LaneRows-1:0]               emrow_q;
  logic signed [CBits-1:0]           snap_q [LaneRows][LaneCols];
  logic                              ov_q;
  logic [SelBits-1:0]                ocol_q;
  logic                              olast_q;
  word_t [OutPairs-1:0]              opair_q;

  logic adv, s1_fire, emit_go, out_free;

  assign out_free   = !ov_q || out_ready_i;
  assign adv        = !busy_q;
  assign op_ready_o = adv;
  assign s1_fire    = s1_q && adv;
  assign emit_go    = s1_fire && s1_emit_q;

  function automatic acc_t sat_add(acc_t a, acc_t p);
    acc_t s;
    s = a + p;
    if (!a[AccBits-1] && !p[AccBits-1] && s[AccBits-1]) s = {1'b0, {(AccBits-1){1'b1}}};
    else if (a[AccBits-1] && p[AccBits-1] && !s[AccBits-1]) s = {1'b1, {(AccBits-1){1'b0}}};
    return s;
  endfunction

  function automatic acc_t load_val(logic signed [CBits-1:0] c);
    logic signed [63:0] v, hi;
    v  = 64'(c) <<< 15;
    hi = (64'sd1 <<< (AccBits - 1)) - 64'sd1;
    if (v > hi) return {1'b0, {(AccBits-1){1'b1}}};
    if (v < -hi - 64'sd1) return {1'b1, {(AccBits-1){1'b0}}};
    return v[AccBits-1:0];
  endfunction

  function automatic logic signed [CBits-1:0] emit_val(acc_t a);
    logic signed [63:0] s;
    s = 64'(a) >>> 15;
    if (s > 64'sd2147483647) return {1'b0, {(CBits-1){1'b1}}};
    if (s < -64'sd2147483648) return {1'b1, {(CBits-1){1'b0}}};
    return s[CBits-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
    end else if (adv) begin
      s1_q <= op_valid_i && (op_i.do_step || op_i.do_load);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_step_q  <= op_i.do_step;
      s1_emit_q  <= op_i.do_emit;
      s1_load_q  <= op_i.do_load;
      s1_sel_q   <= op_i.sel;
      s1_ncols_q <= op_i.ncols;
      s1_row_q   <= op_i.row_en;
      s1_col_q   <= op_i.col_en;
      for (int r = 0; r < LaneRows; r++) begin
        cval_q[r] <= op_i.pay[r/2][(r%2)*CBits +: CBits];
        for (int c = 0; c < LaneCols; c++) begin
          prod_q[r][c] <= $signed(op_i.pay[r/4][(r%4)*QBits +: QBits])
                        * $signed(op_i.pay[4 + c/4][(c%4)*QBits +: QBits]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < TileRows; r++) begin
        for (int c = 0; c < TileCols; c++) begin
          acc_q[r][c] <= '0;
        end
      end
    end else if (s1_fire) begin
      for (int r = 0; r < TileRows; r++) begin
        for (int c = 0; c < TileCols; c++) begin
          if (emit_go) begin
            acc_q[r][c] <= '0;
          end else if (s1_load_q && c == 32'(s1_sel_q)) begin
            if (r < LaneRows && s1_row_q[r % LaneRows])
              acc_q[r][c] <= load_val(cval_q[r % LaneRows]);
            else
              acc_q[r][c] <= '0;
          end else if (s1_step_q && r < LaneRows && c < LaneCols
                       && s1_row_q[r % LaneRows] && s1_col_q[c % LaneCols]) begin
            acc_q[r][c] <= sat_add(acc_q[r][c],
                                   AccBits'(prod_q[r % LaneRows][c % LaneCols]));
          end
        end
      end
    end
  end

  // Snapshot of the final sums of the tile for emission. It shifts down one
  // column for each result sent, so column zero is always the next one out.
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      emrow_q <= s1_row_q;
      for (int r = 0; r < LaneRows; r++) begin
        for (int c = 0; c < LaneCols; c++) begin
          if (r < TileRows && c < TileCols && s1_row_q[r] && s1_col_q[c])
            snap_q[r][c] <= emit_val(sat_add(acc_q[r % TileRows][c % TileCols],
                                             AccBits'(prod_q[r][c])));
          else if (r < TileRows && c < TileCols)
            snap_q[r][c] <= emit_val(acc_q[r % TileRows][c % TileCols]);
          else
            snap_q[r][c] <= '0;
        end
      end
    end else if (busy_q && out_free) begin
      for (int r = 0; r < LaneRows; r++) begin
        for (int c = 0; c + 1 < LaneCols; c++) begin
          snap_q[r][c] <= snap_q[r][c + 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      n_q    <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (busy_q && out_free) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (emit_go && s1_ncols_q != '0) begin
        busy_q <= 1'b1;
        k_q    <= '0;
        n_q    <= s1_ncols_q;
      end else if (busy_q && out_free) begin
        k_q  <= k_q + 3'd1;
        if (k_q + 3'd1 == n_q) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && out_free) begin
      ocol_q  <= k_q;
      olast_q <= (k_q + 3'd1 == n_q);
      for (int p = 0; p < OutPairs; p++) begin
        opair_q[p][CBits-1:0]       <= emrow_q[2*p]   ? snap_q[2*p][0]   : '0;
        opair_q[p][2*CBits-1:CBits] <= emrow_q[2*p+1] ? snap_q[2*p+1][0] : '0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign col_index_o = ocol_q;
  assign last_o      = olast_q;
  assign pair_o      = opair_q;

`ifndef SYNTH
  a_no_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |=> !$rose(ov_q)) else $error("result without emission");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(ocol_q)) else $error("result dropped");
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !op_ready_o) else $error("item taken during emission");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> k_q < n_q) else $error("emit counter overrun");
`endif

endmodule

// File: rtl/outer_product_tile_accumulator_top.sv
// Top level of the outer product tile accumulator.
// Usage: items arrive on the input channel (cmd, col_select, payload0..7).
// A k-step adds the outer product of a 16-element A column and a 6-element
// B row into the 16x6 tile; a preload sets one tile column from C values.
// A final k-step emits cols_used results on the output channel, one column
// each, with the last one flagged, and then clears the tile.
// Configuration writes (index 0 rows_used, index 1 cols_used) go through the
// configuration channel, which is always ready; the user must make them only
// while the block is idle, unchecked by the block. Throughput is one item
// per cycle for k-steps and preloads. An item is registered in the front
// stage, the products are registered in the next, and the tile is updated
// from them. A final k-step snapshots the tile and the emit sequencer sends
// one column per cycle; once the items behind it fill the two stages, input
// is held off while those cols_used columns drain. The first result passes
// the front, stage 1, snapshot and output registers. When the receiver
// stalls, the output register holds its item and the sequencer waits.
// Reset clears the tile, sets rows_used to 16 and cols_used to 6.
module outer_product_tile_accumulator_top
  import opta_pkg::*;
#(
  parameter int unsigned TileRows = TileRowsDef,
  parameter int unsigned TileCols = TileColsDef,
  parameter int unsigned AccBits  = AccBitsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  opta_if.sink  in_ch,
  opta_if.sink  cfg_ch,
  opta_if.source out_ch
);

  logic                 op_valid, op_ready;
  op_t                  op;
  word_t [PayWords-1:0] pay;
  word_t [OutPairs-1:0] pairs;
  logic [SelBits-1:0]   out_col;
  logic                 out_last;

  assign pay = {in_ch.data.payload7, in_ch.data.payload6, in_ch.data.payload5,
                in_ch.data.payload4, in_ch.data.payload3, in_ch.data.payload2,
                in_ch.data.payload1, in_ch.data.payload0};
  assign cfg_ch.ready = 1'b1;

  opta_front #(.TileRows(TileRows), .TileCols(TileCols)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i   (in_ch.valid),
    .in_ready_o   (in_ch.ready),
    .cmd_i        (in_ch.data.cmd),
    .col_select_i (in_ch.data.col_select),
    .pay_i        (pay),
    .cfg_valid_i  (cfg_ch.valid),
    .cfg_index_i  (cfg_ch.data.index),
    .cfg_data_i   (cfg_ch.data.value),
    .op_valid_o   (op_valid),
    .op_ready_i   (op_ready),
    .op_o         (op)
  );

  opta_back #(.TileRows(TileRows), .TileCols(TileCols), .AccBits(AccBits)) u_back (
    .clk_i, .rst_ni,
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_i        (op),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .col_index_o (out_col),
    .last_o      (out_last),
    .pair_o      (pairs)
  );

  assign out_ch.data = out_item_t'{
    col_index: out_col,
    last:      out_last,
    out_pair0: pairs[0],
    out_pair1: pairs[1],
    out_pair2: pairs[2],
    out_pair3: pairs[3],
    out_pair4: pairs[4],
    out_pair5: pairs[5],
    out_pair6: pairs[6],
    out_pair7: pairs[7]
  };

endmodule
